### hdl/mi3_pkg.sv
`timescale 1ns / 1ps
package mi3_pkg;
    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NE         = 9;
    localparam int PW         = 2 * WORD_WIDTH + 1;
    localparam int CW         = 2 * WORD_WIDTH + 1;
    localparam int DW         = 3 * WORD_WIDTH + 3;
    localparam int RW         = DW + 1;
    localparam int NW         = CW + 2 * FRAC_BITS;
    localparam int QDEPTH     = 4;
    localparam int QAW        = 2;

    typedef struct packed {
        logic [NE-1:0][CW-1:0] cmag;
        logic [NE-1:0]         neg;
        logic [DW-1:0]         dmag;
        logic                  singular;
    } t_qitem;
endpackage

### hdl/mi3_front.sv
`timescale 1ns / 1ps
module mi3_front import mi3_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [NE*WORD_WIDTH-1:0] i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_qitem                   o_item
);
    logic                         ce;
    logic [4:0]                   r_v;
    logic signed [WORD_WIDTH-1:0] r_m   [NE];
    logic signed [WORD_WIDTH-1:0] r_m0a [3];
    logic signed [WORD_WIDTH-1:0] r_m0b [3];
    logic signed [2*WORD_WIDTH-1:0] r_pa [NE];
    logic signed [2*WORD_WIDTH-1:0] r_pb [NE];
    logic signed [CW-1:0]         r_cof  [NE];
    logic signed [CW-1:0]         r_cof4 [NE];
    logic signed [PW-1:0]         r_plo  [3];
    logic signed [PW-1:0]         r_phi  [3];
    logic signed [DW-1:0]         det;
    t_qitem                       n_item;
    t_qitem                       r_item;

    assign ce      = !r_v[4] || i_ready;
    // No beat is taken while the reset is held.
    assign o_ready = ce && i_rst_n;
    assign o_valid = r_v[4];
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (ce) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // Stage 1 registers the entries, stage 2 forms the cofactor products,
    // stage 3 the cofactors, stage 4 the split determinant products.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < NE; k++) begin
                r_m[k]    <= $signed(i_data[k*WORD_WIDTH +: WORD_WIDTH]);
                r_cof4[k] <= r_cof[k];
            end
            for (int i = 0; i < 3; i++) begin
                r_m0a[i] <= r_m[i];
                r_m0b[i] <= r_m0a[i];
                r_plo[i] <= r_m0b[i] * $signed({1'b0, r_cof[i*3][WORD_WIDTH-1:0]});
                r_phi[i] <= r_m0b[i] * $signed(r_cof[i*3][CW-1:WORD_WIDTH]);
            end
            r_item <= n_item;
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int K  = gi * 3 + gj;
            localparam int IA = ((gj + 1) % 3) * 3 + (gi + 1) % 3;
            localparam int IB = ((gj + 2) % 3) * 3 + (gi + 2) % 3;
            localparam int IC = ((gj + 1) % 3) * 3 + (gi + 2) % 3;
            localparam int ID = ((gj + 2) % 3) * 3 + (gi + 1) % 3;
            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_pa[K]  <= r_m[IA] * r_m[IB];
                    r_pb[K]  <= r_m[IC] * r_m[ID];
                    r_cof[K] <= CW'(r_pa[K]) - CW'(r_pb[K]);
                end
            end
        end
    end

    always_comb begin
        det = '0;
        for (int i = 0; i < 3; i++) begin
            det = det + (DW'(r_phi[i]) <<< WORD_WIDTH) + DW'(r_plo[i]);
        end
        for (int k = 0; k < NE; k++) begin
            n_item.cmag[k] = r_cof4[k][CW-1] ? CW'(-r_cof4[k]) : CW'(r_cof4[k]);
            n_item.neg[k]  = r_cof4[k][CW-1] ^ det[DW-1];
        end
        n_item.dmag     = det[DW-1] ? DW'(-det) : DW'(det);
        n_item.singular = (det == '0);
    end
endmodule

### hdl/mi3_queue.sv
`timescale 1ns / 1ps
module mi3_queue import mi3_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qitem i_item,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_qitem o_item
);
    t_qitem         r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

### hdl/mi3_back.sv
`timescale 1ns / 1ps
module mi3_back import mi3_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  t_qitem                   i_item,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [NE*WORD_WIDTH-1:0] o_data,
    output logic                     o_singular
);
    localparam int S = WORD_WIDTH;

    logic                  ce;
    logic [S:0]            r_v;
    logic [RW-1:0]         r_rem  [S+1][NE];
    logic [WORD_WIDTH-1:0] r_q    [S+1][NE];
    logic [WORD_WIDTH-1:0] r_nlo  [S+1][NE];
    logic [NE-1:0]         r_neg  [S+1];
    logic [NE-1:0]         r_ovf  [S+1];
    logic [DW-1:0]         r_d    [S+1];
    logic                  r_sing [S+1];
    logic                  r_ov;
    logic [NE*WORD_WIDTH-1:0] r_data;
    logic                  r_osing;
    logic [NW-1:0]         num    [NE];
    logic [RW-1:0]         trial  [S][NE];
    logic [NE*WORD_WIDTH-1:0] n_data;

    assign ce         = !r_ov || i_ready;
    assign o_pop      = ce && !i_empty;
    assign o_valid    = r_ov;
    assign o_data     = r_data;
    assign o_singular = r_osing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (ce) begin
            r_v  <= {r_v[S-1:0], !i_empty};
            r_ov <= r_v[S];
        end
    end

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            num[k] = {i_item.cmag[k], {(2*FRAC_BITS){1'b0}}};
        end
        for (int s = 0; s < S; s++) begin
            for (int k = 0; k < NE; k++) begin
                trial[s][k] = {r_rem[s][k][RW-2:0], r_nlo[s][k][WORD_WIDTH-1]};
            end
        end
    end

    // Restoring division, one quotient bit per stage and lane. Overflow of
    // the word is known up front once the top part of the numerator reaches
    // the divisor.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < NE; k++) begin
                r_rem[0][k] <= RW'(num[k] >> WORD_WIDTH);
                r_nlo[0][k] <= num[k][WORD_WIDTH-1:0];
                r_q[0][k]   <= '0;
                r_ovf[0][k] <= (RW'(num[k] >> WORD_WIDTH) >= RW'(i_item.dmag));
            end
            r_neg[0]  <= i_item.neg;
            r_d[0]    <= i_item.dmag;
            r_sing[0] <= i_item.singular;
            for (int s = 0; s < S; s++) begin
                for (int k = 0; k < NE; k++) begin
                    if (trial[s][k] >= RW'(r_d[s])) begin
                        r_rem[s+1][k] <= trial[s][k] - RW'(r_d[s]);
                        r_q[s+1][k]   <= {r_q[s][k][WORD_WIDTH-2:0], 1'b1};
                    end else begin
                        r_rem[s+1][k] <= trial[s][k];
                        r_q[s+1][k]   <= {r_q[s][k][WORD_WIDTH-2:0], 1'b0};
                    end
                    r_nlo[s+1][k] <= {r_nlo[s][k][WORD_WIDTH-2:0], 1'b0};
                end
                r_neg[s+1]  <= r_neg[s];
                r_ovf[s+1]  <= r_ovf[s];
                r_d[s+1]    <= r_d[s];
                r_sing[s+1] <= r_sing[s];
            end
            r_data  <= n_data;
            r_osing <= r_sing[S];
        end
    end

    always_comb begin
        logic [WORD_WIDTH-1:0] q;
        logic                  sat;
        for (int k = 0; k < NE; k++) begin
            q   = r_q[S][k];
            sat = r_ovf[S][k] || (q[WORD_WIDTH-1] && (!r_neg[S][k] || (|q[WORD_WIDTH-2:0])));
            if (r_sing[S]) begin
                n_data[k*WORD_WIDTH +: WORD_WIDTH] = '0;
            end else if (sat) begin
                n_data[k*WORD_WIDTH +: WORD_WIDTH] = r_neg[S][k]
                    ? {1'b1, {(WORD_WIDTH-1){1'b0}}} : {1'b0, {(WORD_WIDTH-1){1'b1}}};
            end else begin
                n_data[k*WORD_WIDTH +: WORD_WIDTH] = r_neg[S][k] ? (~q + 1'b1) : q;
            end
        end
    end
endmodule

### hdl/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// Inverse of a 3x3 matrix of signed Q16.16 entries by the adjugate.
// The slave channel takes one matrix per beat; the master channel gives one
// inverse per beat, with tuser set when the determinant is exactly zero, in
// which case all nine entries are zero. Entries that do not fit the word
// saturate, and every quotient is truncated towards zero.
// The front end registers the matrix, forms the cofactors and the exact
// determinant in five pipeline stages and writes the result into a queue
// of four beats. The back end pops the queue and runs nine restoring
// dividers side by side, one quotient bit per stage (32 stages), followed
// by the saturation logic in front of the output register.
// Throughput is one matrix per cycle while the master side does not stall,
// as the divider lanes are fully pipelined.
// A synchronous active-low reset empties both pipelines and the queue.
// When the receiver stalls, the back end holds; the front end keeps
// accepting until the queue is full and its last stage holds a result,
// and only then does tready fall.
module matrix_inverse_3x3 import mi3_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ... in_r2c2, 32 bits each
    input  logic [NE*WORD_WIDTH-1:0] i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // out_r0c0, out_r0c1, out_r0c2, out_r1c0, ... out_r2c2, 32 bits each
    output logic [NE*WORD_WIDTH-1:0] o_m_axis_tdata,
    // singular
    output logic                     o_m_axis_tuser
);
    logic   f_valid;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    t_qitem f_item;
    t_qitem q_item;

    mi3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_item  (f_item)
    );

    mi3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !q_full),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    mi3_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata),
        .o_singular (o_m_axis_tuser)
    );
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top import mi3_pkg::*; ();

    localparam int N_RANDOM = 1530;
    localparam int LATENCY  = WORD_WIDTH + 7;

    typedef logic signed [WORD_WIDTH-1:0] t_word;
    typedef struct {
        t_word e [NE];
        logic  singular;
    } t_inverse;

    // The scoreboard holds predicted inverses in arrival order and compares each
    // output beat against the oldest one.
    class inverse_scoreboard;
        t_inverse pending[$];
        int       mismatches;

        function automatic logic signed [255:0] widen(t_word v);
            widen = {{(256 - WORD_WIDTH){v[WORD_WIDTH-1]}}, v};
        endfunction

        // Exact determinant and adjugate, then, unless the determinant is zero, one truncating division per entry.
        function void note_matrix(logic [NE*WORD_WIDTH-1:0] flat);
            logic signed [255:0] m [3][3];
            logic signed [255:0] adj [3][3];
            logic signed [255:0] det, num, quo, lim_hi, lim_lo;
            t_inverse r;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m[i][j] = widen(flat[(i*3+j)*WORD_WIDTH +: WORD_WIDTH]);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    adj[i][j] = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
                              - m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
            det = m[0][0]*adj[0][0] + m[0][1]*adj[1][0] + m[0][2]*adj[2][0];
            lim_hi = (256'sd1 <<< (WORD_WIDTH - 1)) - 1;
            lim_lo = -(256'sd1 <<< (WORD_WIDTH - 1));
            r.singular = (det == 0);
            for (int k = 0; k < NE; k++) begin
                if (r.singular) begin
                    r.e[k] = '0;
                end else begin
                    num = adj[k/3][k%3] <<< (2 * FRAC_BITS);
                    // Signed division truncates towards zero, as required.
                    quo = num / det;
                    if (quo > lim_hi) quo = lim_hi;
                    if (quo < lim_lo) quo = lim_lo;
                    r.e[k] = quo[WORD_WIDTH-1:0];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_inverse(logic [NE*WORD_WIDTH-1:0] flat, logic sing);
            t_inverse x;
            bit bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat at %0t", $time);
                return;
            end
            x = pending.pop_front();
            bad = (sing !== x.singular);
            for (int k = 0; k < NE; k++)
                if (flat[k*WORD_WIDTH +: WORD_WIDTH] !== x.e[k]) bad = 1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: singular exp %0b got %0b", $time,
                             x.singular, sing);
                    for (int k = 0; k < NE; k++)
                        $display("  entry %0d exp %h got %h", k, x.e[k],
                                 flat[k*WORD_WIDTH +: WORD_WIDTH]);
                end
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_axis_tvalid;
    logic                     o_s_axis_tready;
    logic [NE*WORD_WIDTH-1:0] i_s_axis_tdata;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready;
    logic [NE*WORD_WIDTH-1:0] o_m_axis_tdata;
    logic                     o_m_axis_tuser;

    inverse_scoreboard sb = new();
    bit sending_done;

    matrix_inverse_3x3 dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, and now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_word pick_entry(int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS);
            2: return $signed($urandom_range(0, 64)) - 32;
            default: begin
                case ($urandom_range(0, 4))
                    0: return {1'b0, {(WORD_WIDTH-1){1'b1}}};
                    1: return {1'b1, {(WORD_WIDTH-1){1'b0}}};
                    2: return '0;
                    3: return 1 << FRAC_BITS;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    // Drives one matrix beat and holds it until the handshake completes.
    task automatic send_matrix(logic [NE*WORD_WIDTH-1:0] flat);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= flat;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_matrix(flat);
    endtask

    function automatic logic [NE*WORD_WIDTH-1:0] pack3(t_word a [NE]);
        logic [NE*WORD_WIDTH-1:0] f;
        for (int k = 0; k < NE; k++) f[k*WORD_WIDTH +: WORD_WIDTH] = a[k];
        return f;
    endfunction

    task automatic run_stimulus();
        t_word a [NE];
        int style;
        // Directed: identity, zero, singular rows, extremes, saturation cases.
        for (int d = 0; d < 20; d++) begin
            for (int k = 0; k < NE; k++) a[k] = '0;
            case (d)
                0: for (int k = 0; k < 3; k++) a[k*4] = 1 << FRAC_BITS;
                1: ;
                2: for (int k = 0; k < NE; k++) a[k] = {1'b0, {(WORD_WIDTH-1){1'b1}}};
                3: for (int k = 0; k < NE; k++) a[k] = {1'b1, {(WORD_WIDTH-1){1'b0}}};
                4: for (int k = 0; k < 3; k++) a[k*4] = 1;
                5: for (int k = 0; k < 3; k++) a[k*4] = -1;
                6: for (int k = 0; k < 3; k++) a[k*4] = {1'b1, {(WORD_WIDTH-1){1'b0}}};
                7: for (int k = 0; k < 3; k++) a[k*4] = {1'b0, {(WORD_WIDTH-1){1'b1}}};
                8: for (int k = 0; k < NE; k++) a[k] = -1;
                9: begin
                    a[0] = 2 << FRAC_BITS; a[4] = -(3 << FRAC_BITS);
                    a[8] = 5 << FRAC_BITS; a[1] = 7; a[5] = -9;
                end
                default: begin
                    for (int k = 0; k < NE; k++) a[k] = pick_entry(d % 4);
                    // Copy a row into another to force a zero determinant.
                    if (d % 3 == 0) for (int k = 0; k < 3; k++) a[3+k] = a[k];
                end
            endcase
            send_matrix(pack3(a));
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            style = $urandom_range(0, 3);
            for (int k = 0; k < NE; k++)
                a[k] = ($urandom_range(0, 7) == 0) ? pick_entry(3) : pick_entry(style);
            if ($urandom_range(0, 15) == 0)
                for (int k = 0; k < 3; k++) a[6+k] = a[3+k];
            send_matrix(pack3(a));
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    // Receiver: random back-pressure, checking on every completed handshake.
    initial begin
        int hold;
        i_m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_inverse(o_m_axis_tdata, o_m_axis_tuser);
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else begin
                hold = pick_gap();
                i_m_axis_tready <= (hold == 0);
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_stimulus();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Generous limit: every beat may wait out long gaps on both sides.
    initial begin
        #(2_000_000 * 10);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
